FILE: rtl/rsi_pkg.sv
// Package for the ray/sphere intersection block: default widths, register
// indexes and the epsilon helper. No dependencies.
package rsi_pkg;

  localparam int unsigned CoordWidthDef = 32;
  localparam int unsigned FracBitsDef   = 16;

  // Configuration register indexes
  localparam logic [1:0] RegCenterX = 2'd0;
  localparam logic [1:0] RegCenterY = 2'd1;
  localparam logic [1:0] RegCenterZ = 2'd2;
  localparam logic [1:0] RegRadius  = 2'd3;

  // 1e-4 rounded to nearest at the given number of fraction bits
  function automatic longint unsigned eps_q(input int unsigned frac);
    longint unsigned one;
    one = 64'd1 << frac;
    return (one + 64'd5000) / 64'd10000;
  endfunction

endpackage

FILE: rtl/rsi_isqrt.sv
// Pipelined integer square root, one result bit per stage (restoring method).
// Depends on nothing; used by ray_sphere_intersect.
module rsi_isqrt #(
  parameter int unsigned InWidth  = 96,
  parameter int unsigned TagWidth = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [InWidth-1:0]    rad_i,
  input  logic [TagWidth-1:0]   tag_i,
  output logic                  valid_o,
  output logic [InWidth/2-1:0]  root_o,
  output logic [TagWidth-1:0]   tag_o
);

  localparam int unsigned RootW = InWidth / 2;
  localparam int unsigned RemW  = RootW + 2;

  logic [RootW:1]               vld_q;
  logic [InWidth-1:0]           rad_q  [1:RootW];
  logic [RootW-1:0]             root_q [1:RootW];
  logic [RemW-1:0]              rem_q  [1:RootW];
  logic [TagWidth-1:0]          tag_q  [1:RootW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[RootW-1:1], valid_i};
    end
  end

  for (genvar g = 0; g < RootW; g++) begin : g_stage
    logic [InWidth-1:0]   rad_in;
    logic [RootW-1:0]     root_in;
    logic [RemW-1:0]      rem_in;
    logic [TagWidth-1:0]  tag_in;
    logic [RemW-1:0]      rem_sh;
    logic [RemW-1:0]      trial;
    logic [RemW:0]        diff;

    // stage 0 takes the input directly
    if (g == 0) begin : g_first
      assign rad_in  = rad_i;
      assign root_in = '0;
      assign rem_in  = '0;
      assign tag_in  = tag_i;
    end else begin : g_next
      assign rad_in  = rad_q[g];
      assign root_in = root_q[g];
      assign rem_in  = rem_q[g];
      assign tag_in  = tag_q[g];
    end

    always_comb begin
      rem_sh = {rem_in[RemW-3:0], rad_in[InWidth-1 -: 2]};
      trial  = {root_in, 2'b01};
      diff   = {1'b0, rem_sh} - {1'b0, trial};
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[g+1] <= {rad_in[InWidth-3:0], 2'b00};
        tag_q[g+1] <= tag_in;
        if (!diff[RemW]) begin
          rem_q[g+1]  <= diff[RemW-1:0];
          root_q[g+1] <= {root_in[RootW-2:0], 1'b1};
        end else begin
          rem_q[g+1]  <= rem_sh;
          root_q[g+1] <= {root_in[RootW-2:0], 1'b0};
        end
      end
    end
  end

  assign valid_o = vld_q[RootW];
  assign root_o  = root_q[RootW];
  assign tag_o   = tag_q[RootW];

endmodule

FILE: rtl/ray_sphere_intersect.sv
// Ray/sphere intersection top level: register file, dot-product pipeline,
// discriminant, square root and root selection. Uses rsi_pkg and rsi_isqrt.
//
// One ray enters per cycle while the pipeline advances, and one result leaves
// per ray, in order. A ray passes through five front stages, one square-root
// stage per root bit (COORD_WIDTH + 6 of them), then root selection and the
// output register. The whole pipeline advances whenever the output register
// is empty or being taken, so back-pressure stalls every stage together and
// loses nothing. The user must write the sphere registers through the cfg
// port only while no ray is in flight; the block does not enforce it.
module ray_sphere_intersect #(
  parameter int unsigned COORD_WIDTH = rsi_pkg::CoordWidthDef,
  parameter int unsigned FRAC_BITS   = rsi_pkg::FracBitsDef,
  localparam int unsigned DirW  = FRAC_BITS + 2,
  localparam int unsigned RadW  = COORD_WIDTH - 1,
  localparam int unsigned InW   = 3 * COORD_WIDTH + 3 * DirW,
  localparam int unsigned InBW  = ((InW + 7) / 8) * 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // cfg
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_addr_i,
  input  logic [COORD_WIDTH-1:0] cfg_wdata_i,
  // rays: origin_x, origin_y, origin_z, dir_x, dir_y, dir_z (low bit up)
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [InBW-1:0]        s_axis_tdata,
  // results: hit, line_hit, distance[30:0] (low bit up)
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [39:0]            m_axis_tdata
);

  localparam int unsigned OpW   = COORD_WIDTH + 1;
  localparam int unsigned PdW   = OpW + DirW;          // op*dir
  localparam int unsigned BsW   = PdW + 2;             // sum of three
  localparam int unsigned BW    = BsW - FRAC_BITS;     // b
  localparam int unsigned SqW   = 2 * OpW;             // op*op
  localparam int unsigned SsW   = SqW + 2;
  localparam int unsigned DetW  = 2 * BW + 2;          // signed det width
  localparam int unsigned SqInW = ((DetW + 1) / 2) * 2;
  localparam int unsigned RootW = SqInW / 2;
  localparam int unsigned TW    = BW + 2;              // root width
  localparam int unsigned Lat0  = 5;
  localparam logic [TW-1:0] Eps = TW'(rsi_pkg::eps_q(FRAC_BITS));
  localparam logic [TW-1:0] DMax = TW'(32'h7FFF_FFFF);

  // configuration registers
  logic signed [COORD_WIDTH-1:0] cen_q [3];
  logic [RadW-1:0]               rad_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cen_q[0] <= '0;
      cen_q[1] <= '0;
      cen_q[2] <= '0;
      rad_q    <= RadW'(32'd65536);
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        rsi_pkg::RegCenterX: cen_q[0] <= cfg_wdata_i;
        rsi_pkg::RegCenterY: cen_q[1] <= cfg_wdata_i;
        rsi_pkg::RegCenterZ: cen_q[2] <= cfg_wdata_i;
        rsi_pkg::RegRadius:  rad_q <= cfg_wdata_i[RadW-1:0];
        default: ;
      endcase
    end
  end

  // global advance
  logic out_vld_q, en;
  assign en = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  logic [Lat0-1:0] v_q;
  logic [TW-1:0]   tag_unused;

  // stage 1: op = c - o, capture dir
  logic signed [OpW-1:0]  op1_q [3];
  logic signed [DirW-1:0] d1_q  [3];
  // stage 2: products
  logic signed [PdW-1:0]  pd2_q [3];
  logic signed [SqW-1:0]  sq2_q [3];
  logic [2*RadW-1:0]      r2_q;
  // stage 3: sums, b
  logic signed [BW-1:0]   b3_q;
  logic signed [SsW-1:0]  ss3_q;
  logic [2*RadW-1:0]      r3_q;
  // stage 4: b squared, r^2 - op.op
  logic signed [2*BW-1:0] bb4_q;
  logic signed [DetW-1:0] rs4_q;
  logic signed [BW-1:0]   b4_q;
  // stage 5: det
  logic signed [DetW-1:0] det5_q;
  logic signed [BW-1:0]   b5_q;

  logic signed [BsW-1:0]  bsum;
  always_comb begin
    bsum = BsW'(pd2_q[0]) + BsW'(pd2_q[1]) + BsW'(pd2_q[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else if (en) v_q <= {v_q[Lat0-2:0], s_axis_tvalid};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        op1_q[i] <= OpW'(cen_q[i]) -
          OpW'($signed(s_axis_tdata[i*COORD_WIDTH +: COORD_WIDTH]));
        d1_q[i]  <= s_axis_tdata[3*COORD_WIDTH + i*DirW +: DirW];
        pd2_q[i] <= PdW'(op1_q[i]) * PdW'(d1_q[i]);
        sq2_q[i] <= SqW'(op1_q[i]) * SqW'(op1_q[i]);
      end
      r2_q   <= rad_q * rad_q;
      b3_q   <= BW'(bsum >>> FRAC_BITS);
      ss3_q  <= SsW'(sq2_q[0]) + SsW'(sq2_q[1]) + SsW'(sq2_q[2]);
      r3_q   <= r2_q;
      bb4_q  <= b3_q * b3_q;
      rs4_q  <= DetW'({1'b0, r3_q}) - DetW'(ss3_q);
      b4_q   <= b3_q;
      det5_q <= DetW'(bb4_q) + rs4_q;
      b5_q   <= b4_q;
    end
  end

  // square root; line_hit and b ride along as tag
  logic              sq_vld;
  logic [RootW-1:0]  root;
  logic [BW:0]       sq_tag;
  rsi_isqrt #(.InWidth(SqInW), .TagWidth(BW + 1)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v_q[Lat0-1]),
    .rad_i   (det5_q[DetW-1] ? '0 : SqInW'(det5_q)),
    .tag_i   ({~det5_q[DetW-1], b5_q}),
    .valid_o (sq_vld),
    .root_o  (root),
    .tag_o   (sq_tag)
  );

  // root selection stage 1: both roots
  logic              rv_q, line_q;
  logic signed [TW-1:0] t0_q, t1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rv_q <= 1'b0;
    else if (en) rv_q <= sq_vld;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      line_q <= sq_tag[BW];
      t0_q   <= TW'($signed(sq_tag[BW-1:0])) - TW'({1'b0, root});
      t1_q   <= TW'($signed(sq_tag[BW-1:0])) + TW'({1'b0, root});
    end
  end
  assign tag_unused = '0;

  // root selection stage 2: pick, saturate, output register
  logic hit_d;
  logic [TW-1:0] t_d;
  logic [30:0] dist_d;
  always_comb begin
    hit_d = 1'b0;
    t_d   = tag_unused;
    if (line_q) begin
      if (t0_q > $signed(Eps)) begin
        hit_d = 1'b1; t_d = t0_q;
      end else if (t1_q > $signed(Eps)) begin
        hit_d = 1'b1; t_d = t1_q;
      end
    end
    dist_d = !hit_d ? 31'd0 : (t_d > DMax ? 31'h7FFF_FFFF : t_d[30:0]);
  end

  logic hit_q, lh_q;
  logic [30:0] dist_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (en) out_vld_q <= rv_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q  <= hit_d;
      lh_q   <= line_q;
      dist_q <= dist_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'd0, dist_q, lh_q, hit_q};

endmodule
